/* rtl/qtt_pkg.sv */
package qtt_pkg;

    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_END    = 3'd1,
        KIND_EQ     = 3'd2,
        KIND_ADD_EQ = 3'd3,
        KIND_SUB_EQ = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    // results caused by one item, cnt is 0..2
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_group;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    function automatic t_group f_push(t_group g, t_kind k, logic [7:0] b);
        t_group r;
        r = g;
        if (g.cnt == 2'd0) begin
            r.r0.kind = k;
            r.r0.data = b;
        end else begin
            r.r1.kind = k;
            r.r1.data = b;
        end
        r.cnt = g.cnt + 2'd1;
        return r;
    endfunction

endpackage

/* rtl/qtt_front.sv */
module qtt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_operation,
    input  logic [7:0]      i_ch,
    output logic            o_push,
    output qtt_pkg::t_group o_group
);
    import qtt_pkg::*;

    logic       r_in_quotes, n_in_quotes;
    logic       r_escape, n_escape;
    logic       r_skip, n_skip;
    logic       r_held_valid, n_held_valid;
    logic [7:0] r_held_byte, n_held_byte;
    logic       r_token, n_token;

    t_group     g;
    logic       handled;
    logic [7:0] b;

    always_comb begin
        n_in_quotes  = r_in_quotes;
        n_escape     = r_escape;
        n_skip       = r_skip;
        n_held_valid = r_held_valid;
        n_held_byte  = r_held_byte;
        n_token      = r_token;
        g            = '0;
        handled      = 1'b0;
        b            = i_ch;

        if (i_operation) begin
            if (n_held_valid) begin
                g = f_push(g, KIND_BYTE, n_held_byte);
                n_token = 1'b1;
                n_held_valid = 1'b0;
            end
            if (n_token) begin
                g = f_push(g, KIND_END, 8'h00);
                n_token = 1'b0;
            end
            n_in_quotes = 1'b0;
            n_escape    = 1'b0;
            n_skip      = 1'b0;
        end else if (!r_skip) begin
            if (!r_escape) begin
                if (b == CH_QUOTE) begin
                    n_in_quotes = !r_in_quotes;
                    handled = 1'b1;
                end else if (b == CH_BSL) begin
                    n_escape = 1'b1;
                    handled = 1'b1;
                end
            end
            if (!handled && !r_in_quotes) begin
                if (b == CH_HASH) begin
                    n_skip = 1'b1;
                    handled = 1'b1;
                end else if (b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF) begin
                    if (n_held_valid) begin
                        g = f_push(g, KIND_BYTE, n_held_byte);
                        n_token = 1'b1;
                        n_held_valid = 1'b0;
                    end
                    if (n_token) begin
                        g = f_push(g, KIND_END, 8'h00);
                        n_token = 1'b0;
                    end
                    handled = 1'b1;
                end else if (b == CH_EQ) begin
                    if (n_token) begin
                        g = f_push(g, KIND_END, 8'h00);
                        n_token = 1'b0;
                    end
                    if (r_held_valid) begin
                        g = f_push(g, (r_held_byte == CH_PLUS) ? KIND_ADD_EQ : KIND_SUB_EQ,
                                   8'h00);
                        n_held_valid = 1'b0;
                    end else begin
                        g = f_push(g, KIND_EQ, 8'h00);
                    end
                    handled = 1'b1;
                end
            end
            if (!handled) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                    if (b == CH_N) begin
                        b = CH_LF;
                    end else if (b == CH_T) begin
                        b = CH_TAB;
                    end else if (b == CH_R) begin
                        b = CH_CR;
                    end
                end
                if (n_held_valid) begin
                    g = f_push(g, KIND_BYTE, n_held_byte);
                    n_token = 1'b1;
                    n_held_valid = 1'b0;
                end
                if (b == CH_PLUS || b == CH_MINUS) begin
                    n_held_valid = 1'b1;
                    n_held_byte  = b;
                end else begin
                    g = f_push(g, KIND_BYTE, b);
                    n_token = 1'b1;
                end
            end
        end
    end

    assign o_push  = i_accept && (g.cnt != 2'd0);
    assign o_group = g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quotes  <= 1'b0;
            r_escape     <= 1'b0;
            r_skip       <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_byte  <= 8'h00;
            r_token      <= 1'b0;
        end else if (i_accept) begin
            r_in_quotes  <= n_in_quotes;
            r_escape     <= n_escape;
            r_skip       <= n_skip;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
            r_token      <= n_token;
        end
    end

endmodule

/* rtl/qtt_fifo.sv */
module qtt_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qtt_pkg::t_group i_data,
    input  logic            i_pop,
    output qtt_pkg::t_group o_data,
    output logic            o_full,
    output logic            o_empty
);
    import qtt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

/* rtl/qtt_back.sv */
module qtt_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qtt_pkg::t_group i_group,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [2:0]      o_kind,
    output logic [7:0]      o_byte_out,
    output logic            o_last
);
    import qtt_pkg::*;

    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_idx;
    logic       load;
    logic       is_last;
    t_res       sel;

    assign load    = !r_valid || i_out_ready;
    assign sel     = r_idx ? i_group.r1 : i_group.r0;
    assign is_last = r_idx || (i_group.cnt != 2'd2);
    assign o_pop   = load && !i_empty && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_idx <= !is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_kind <= sel.kind;
            r_byte <= sel.data;
            r_last <= is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_kind      = r_kind;
    assign o_byte_out  = r_byte;
    assign o_last      = r_last;

endmodule

/* rtl/quoted_text_tokenizer_top.sv */
// Quoted-text tokenizer.
// Input channel (i_in_valid / o_in_ready): one item per accepted cycle,
// i_operation = 0 for a text byte in i_ch, 1 for end of line.
// Output channel (o_out_valid / i_out_ready): one result per cycle while
// i_out_ready is high; o_kind = token byte, token end, '=', '+=' or '-=';
// o_byte_out carries the byte for token bytes and is zero otherwise;
// o_last marks the final result of an item. An item gives zero, one or two
// results. Each item's group is written into the queue at the accepting
// edge; the serializer then loads its first result into the output register.
// Throughput: one item per cycle while items average at most one result;
// the output register drains one result per cycle while i_out_ready is high,
// and a group queue of FIFO_DEPTH entries between the classifier and the
// serializer absorbs items that give two results.
// o_in_ready drops only when that queue is full, so a stalled receiver
// backs up into the queue and then holds the input; no result is lost.
// Reset (synchronous, active low) clears quoting, escape, comment and
// held-byte state, empties the queue and drops o_out_valid.
module quoted_text_tokenizer_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [7:0] i_ch,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_kind,
    output logic [7:0] o_byte_out,
    output logic       o_last
);
    import qtt_pkg::*;

    logic   accept;
    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_group grp_in;
    t_group grp_out;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    qtt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_ch        (i_ch),
        .o_push      (push),
        .o_group     (grp_in)
    );

    qtt_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (grp_in),
        .i_pop   (pop),
        .o_data  (grp_out),
        .o_full  (full),
        .o_empty (empty)
    );

    qtt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_group     (grp_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_byte_out  (o_byte_out),
        .o_last      (o_last)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import qtt_pkg::*;

    localparam logic OP_TEXT = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_token_result;

    class token_scoreboard;
        bit             in_quotes;
        bit             escape_pending;
        bit             skip_line;
        bit             held_valid;
        logic [7:0]     held_byte;
        bit             token_open;
        t_token_result  item_results[$];
        t_token_result  pending_results[$];
        int             error_count;

        function void put(t_kind k, logic [7:0] b);
            t_token_result r;
            r.kind = k;
            r.data = b;
            r.last = 1'b0;
            item_results = {item_results, r};
        endfunction

        function void flush_held();
            if (held_valid) begin
                put(KIND_BYTE, held_byte);
                token_open = 1'b1;
                held_valid = 1'b0;
            end
        endfunction

        function void close_token();
            flush_held();
            if (token_open) begin
                put(KIND_END, 8'h00);
                token_open = 1'b0;
            end
        endfunction

        // returns 0 when the item is swallowed by a comment
        function bit note_item(logic op, logic [7:0] c);
            logic [7:0] b;
            t_kind      op_kind;
            bit         taken;
            bit         counted;
            b = c;
            taken = 1'b0;
            counted = 1'b1;
            item_results.delete();
            if (op == OP_EOL) begin
                close_token();
                in_quotes = 1'b0;
                escape_pending = 1'b0;
                skip_line = 1'b0;
            end else if (skip_line) begin
                counted = 1'b0;
            end else begin
                if (!escape_pending) begin
                    if (b == CH_QUOTE) begin
                        in_quotes = !in_quotes;
                        taken = 1'b1;
                    end else if (b == CH_BSL) begin
                        escape_pending = 1'b1;
                        taken = 1'b1;
                    end
                end
                // escaped separators and '#' still act outside quotes
                if (!taken && !in_quotes) begin
                    if (b == CH_HASH) begin
                        skip_line = 1'b1;
                        taken = 1'b1;
                    end else if (b inside {CH_SP, CH_TAB, CH_CR, CH_LF}) begin
                        close_token();
                        taken = 1'b1;
                    end else if (b == CH_EQ) begin
                        op_kind = KIND_EQ;
                        if (held_valid) begin
                            op_kind = (held_byte == CH_PLUS) ? KIND_ADD_EQ : KIND_SUB_EQ;
                            held_valid = 1'b0;
                        end
                        if (token_open) begin
                            put(KIND_END, 8'h00);
                            token_open = 1'b0;
                        end
                        put(op_kind, 8'h00);
                        taken = 1'b1;
                    end
                end
                if (!taken) begin
                    if (escape_pending) begin
                        escape_pending = 1'b0;
                        case (b)
                            CH_N:    b = CH_LF;
                            CH_T:    b = CH_TAB;
                            CH_R:    b = CH_CR;
                            default: b = b;
                        endcase
                    end
                    flush_held();
                    if (b == CH_PLUS || b == CH_MINUS) begin
                        held_valid = 1'b1;
                        held_byte = b;
                    end else begin
                        put(KIND_BYTE, b);
                        token_open = 1'b1;
                    end
                end
            end
            if (item_results.size() > 0)
                item_results[item_results.size() - 1].last = 1'b1;
            foreach (item_results[k])
                pending_results = {pending_results, item_results[k]};
            return counted;
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] data, logic last);
            t_token_result exp;
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d byte_out %0h last %0b", kind, data, last);
                error_count++;
                return;
            end
            exp = pending_results.pop_front();
            if (kind !== 3'(exp.kind)) begin
                $error("kind: expected %0d, actual %0d", exp.kind, kind);
                error_count++;
            end
            if (data !== exp.data) begin
                $error("byte_out: expected %0h, actual %0h", exp.data, data);
                error_count++;
            end
            if (last !== exp.last) begin
                $error("last: expected %0b, actual %0b", exp.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_operation = 1'b0;
    logic [7:0] i_ch = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_kind;
    logic [7:0] o_byte_out;
    logic       o_last;

    token_scoreboard sb = new();
    int          items_done = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    logic [15:0] stall_mask = '1;
    bit          drained_mid = 1'b0;
    string       word_chars = "abcdefxyzKLMQ0189_.";

    quoted_text_tokenizer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_ch        (i_ch),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_byte_out  (o_byte_out),
        .o_last      (o_last)
    );

    always #10 i_clk = ~i_clk;

    // receiver: stall pattern reloaded whenever stall_left runs out
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_kind, o_byte_out, o_last);
        if (stall_left == 0) begin
            stall_left = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0:       stall_mask = '1;
                1:       stall_mask = 16'($urandom);
                2:       stall_mask = 16'($urandom) & 16'($urandom);
                default: stall_mask = 16'($urandom) | 16'($urandom);
            endcase
        end
        stall_left--;
        stall_mask = {stall_mask[0], stall_mask[15:1]};
        i_out_ready <= stall_mask[0];
    end

    task automatic send_item(input logic op, input logic [7:0] c);
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_ch <= c;
        do @(posedge i_clk); while (!o_in_ready);
        void'(sb.note_item(op, c));
        items_done++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(OP_TEXT, s[k]);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic logic [7:0] line_byte();
        case ($urandom_range(0, 15))
            0:       return CH_SP;
            1:       return CH_EQ;
            2:       return CH_PLUS;
            3:       return CH_MINUS;
            4:       return CH_HASH;
            5:       return CH_TAB;
            6:       return 8'($urandom_range(0, 255));
            default: return word_chars[$urandom_range(0, word_chars.len() - 1)];
        endcase
    endfunction

    task automatic send_word();
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0)
                send_item(OP_TEXT, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            else
                send_item(OP_TEXT, word_chars[$urandom_range(0, word_chars.len() - 1)]);
        end
    endtask

    task automatic send_quoted();
        int n;
        n = $urandom_range(0, 6);
        send_item(OP_TEXT, CH_QUOTE);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                send_item(OP_TEXT, CH_BSL);
            send_item(OP_TEXT, line_byte());
        end
        if ($urandom_range(0, 4) != 0)
            send_item(OP_TEXT, CH_QUOTE);
    endtask

    task automatic send_line();
        int parts;
        parts = $urandom_range(1, 6);
        repeat (parts) begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_word();
                3: begin
                    case ($urandom_range(0, 3))
                        0:       send_item(OP_TEXT, CH_SP);
                        1:       send_item(OP_TEXT, CH_TAB);
                        2:       send_item(OP_TEXT, CH_CR);
                        default: send_item(OP_TEXT, CH_LF);
                    endcase
                end
                4: begin
                    if ($urandom_range(0, 2) != 0)
                        send_item(OP_TEXT, $urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                    send_item(OP_TEXT, CH_EQ);
                end
                5: send_quoted();
                6: begin
                    send_item(OP_TEXT, CH_BSL);
                    case ($urandom_range(0, 9))
                        0:       send_item(OP_TEXT, CH_N);
                        1:       send_item(OP_TEXT, CH_T);
                        2:       send_item(OP_TEXT, CH_R);
                        3:       send_item(OP_TEXT, CH_QUOTE);
                        4:       send_item(OP_TEXT, CH_BSL);
                        5:       send_item(OP_TEXT, CH_PLUS);
                        6:       send_item(OP_TEXT, CH_HASH);
                        7:       send_item(OP_TEXT, CH_SP);
                        8:       send_item(OP_TEXT, CH_EQ);
                        default: send_item(OP_TEXT, line_byte());
                    endcase
                end
                7: begin
                    send_item(OP_TEXT, CH_HASH);
                    repeat ($urandom_range(0, 3)) send_item(OP_TEXT, line_byte());
                end
                default: send_item(OP_TEXT, line_byte());
            endcase
        end
        send_item(OP_EOL, 8'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_TEXT, 8'h00);
        send_item(OP_TEXT, 8'hFF);
        send_text("x+=");
        send_text("-=");
        send_text("\"a b=\"");
        send_text("\\ n");
        send_text("\\\"\\t");
        send_text("c+\\#z");
        send_item(OP_EOL, 8'hFF);
        i_in_valid <= 1'b0;
        wait_drained();

        while (items_done < 470) begin
            if (!drained_mid && items_done >= 240) begin
                i_in_valid <= 1'b0;
                wait_drained();
                drained_mid = 1'b1;
            end
            case ($urandom_range(0, 19))
                0, 1, 2: repeat ($urandom_range(1, 12)) send_item(OP_TEXT, 8'($urandom));
                3:       send_item(OP_EOL, 8'($urandom));
                default: send_line();
            endcase
        end
        i_in_valid <= 1'b0;
        wait_drained();
        repeat (80) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
